@@ hw/rtl/grt2d_pkg.sv @@
// Package for the 2-D grid ray traversal block: item types, result kinds,
// fixed-point widths and the quarter-wave sine table built at elaboration.
// No dependencies.
`default_nettype none

package grt2d_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ANGLE_BITS      = 10;
  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned COORD_W         = 5 + COORD_FRAC_BITS;
  localparam int unsigned DIST_W          = COORD_FRAC_BITS + 1;
  localparam int unsigned GRID_SIZE_DEF   = 32;
  localparam int unsigned MAX_RESULTS     = 64;
  localparam int unsigned QUARTER         = 2 ** (ANGLE_BITS - 2);

  // Divider widths: numerator dist << (30 - F), denominator Q1.14 magnitude
  localparam int unsigned NUM_W = 31;
  localparam int unsigned DEN_W = 15;
  localparam int unsigned T_W   = 24;
  localparam logic [T_W-1:0] T_SAT = '1;
  localparam logic [DEN_W-1:0] ONE_Q14 = 15'd16384;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TRACE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_OPEN       = 2'd0,
    KIND_WALL       = 2'd1,
    KIND_LEFT       = 2'd2,
    KIND_START_WALL = 2'd3
  } kind_e;

  typedef struct packed {
    logic                  cmd;
    logic [4:0]            cell_x;
    logic [4:0]            cell_y;
    logic                  wall_bit;
    logic [COORD_W-1:0]    start_x;
    logic [COORD_W-1:0]    start_y;
    logic [ANGLE_BITS-1:0] ray_angle;
  } in_item_t;

  typedef struct packed {
    logic [9:0] cell_index;
    kind_e      kind;
    logic       last;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef logic [DEN_W-1:0] sin_tab_t [QUARTER];

  // Build the Q1.14 sine table from the Q30 odd polynomial
  function automatic sin_tab_t gen_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] r;
    for (int p = 0; p < QUARTER; p++) begin
      if (p == 0) begin
        tab[p] = '0;
      end else begin
        x  = 64'(p) << (32 - ANGLE_BITS);
        x2 = (x * x) >> 30;
        b  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
        b  = 64'd85569306 - ((x2 * b) >> 30);
        b  = 64'd693598668 - ((x2 * b) >> 30);
        b  = 64'd1686629713 - ((x2 * b) >> 30);
        s  = (x * b) >> 30;
        r  = (s + 64'd32768) >> 16;
        if (r > 64'd16384) begin
          r = 64'd16384;
        end
        tab[p] = DEN_W'(r);
      end
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = gen_sin_tab();

endpackage

`default_nettype wire

@@ hw/rtl/grt2d_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module grt2d_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/grt2d_div.sv @@
// Restoring divider, one quotient bit per cycle, for the t value setup.
// Depends on grt2d_pkg.
`default_nettype none

module grt2d_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire grt2d_pkg::div_req_t req_i,
  output grt2d_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned NumW = grt2d_pkg::NUM_W;
  localparam int unsigned DenW = grt2d_pkg::DEN_W;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      num_d = {num_q[NumW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  // Done pulses only after a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider busy while done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider count ran out while busy");

endmodule

`default_nettype wire

@@ hw/rtl/grid_ray_traversal_2d_top.sv @@
// Top level of the 2-D grid ray traversal block: command decode, setup,
// cell stepper and output register. Depends on grt2d_pkg, grt2d_ram and
// grt2d_div.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_item_i) takes write and
//   trace items. A write item updates one wall bit of the map and gives
//   no result. A trace item gives 1 to 64 result items on the
//   output channel (out_valid_o, out_stall_i, out_item_o), the last one
//   flagged by last.
//   A trace reads the start cell, then runs four t value divisions (start,
//   31 quotient bits, done) on the single one-bit-per-cycle divider, then
//   for each cell entered steps, reads the map and registers the output.
//   The block works on one item at a time and stalls the input until the
//   last result of a trace is taken.
//   After reset the map is cleared one cell per cycle, all GRID_SIZE squared
//   cells (1024 at the default size), with the input stalled.
//   When the receiver stalls, the pending result holds in the output
//   register and stepping waits.
`default_nettype none

module grid_ray_traversal_2d_top #(
  parameter int unsigned GRID_SIZE = grt2d_pkg::GRID_SIZE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire grt2d_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output grt2d_pkg::out_item_t      out_item_o
);

  localparam int unsigned Depth  = GRID_SIZE * GRID_SIZE;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned F      = grt2d_pkg::COORD_FRAC_BITS;
  localparam int unsigned AB     = grt2d_pkg::ANGLE_BITS;
  localparam int unsigned DistW  = grt2d_pkg::DIST_W;
  localparam int unsigned TW     = grt2d_pkg::T_W;
  localparam int unsigned DenW   = grt2d_pkg::DEN_W;
  localparam int unsigned NumW   = grt2d_pkg::NUM_W;
  localparam int unsigned CntRW  = $clog2(grt2d_pkg::MAX_RESULTS);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_START_CHK = 7'b0000100,
    ST_DIV       = 7'b0001000,
    ST_STEP      = 7'b0010000,
    ST_CELL_CHK  = 7'b0100000,
    ST_OUT       = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [4:0]           cx_q, cx_d, cy_q, cy_d;
  logic [F-1:0]         fx_q, fx_d, fy_q, fy_d;
  logic [DenW-1:0]      cmag_q, cmag_d, smag_q, smag_d;
  logic                 cneg_q, cneg_d, sneg_q, sneg_d;
  logic [TW-1:0]        tmx_q, tmx_d, tmy_q, tmy_d, tdx_q, tdx_d, tdy_q, tdy_d;
  logic [1:0]           sel_q, sel_d;
  logic                 go_q, go_d;
  logic [CntRW-1:0]     n_q, n_d;
  logic                 out_valid_q, out_valid_d;
  grt2d_pkg::out_item_t out_q, out_d;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic                 wdata, rdata;
  grt2d_pkg::div_req_t  div_req;
  grt2d_pkg::div_rsp_t  div_rsp;

  // Combinational helpers
  logic [4:0]           in_cx, in_cy, nx, ny;
  logic [1:0]           quad;
  logic [AB-3:0]        phase;
  logic [AB-2:0]        ph_lo, ph_hi;
  logic [DenW-1:0]      mag_lo, mag_hi, in_smag, in_cmag;
  logic [DistW-1:0]     span;
  logic [TW-1:0]        tq;
  logic                 step_x, leave;
  logic [9:0]           cur_idx, nxt_idx, in_idx, wr_idx;

  function automatic logic [9:0] cell_idx(input logic [4:0] r, input logic [4:0] c);
    return 10'(10'(r) * 10'(GRID_SIZE) + 10'(c));
  endfunction

  function automatic logic [DenW-1:0] sin_mag(input logic [AB-2:0] v);
    logic [DenW-1:0] m;
    if (v == '0) begin
      m = '0;
    end else if (v[AB-2]) begin
      m = grt2d_pkg::ONE_Q14;
    end else begin
      m = grt2d_pkg::SIN_TAB[v[AB-3:0]];
    end
    return m;
  endfunction

  function automatic logic [TW-1:0] t_sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? grt2d_pkg::T_SAT : s[TW-1:0];
  endfunction

  // Decode the start cell and the direction of an incoming trace
  assign in_cx   = in_item_i.start_x[grt2d_pkg::COORD_W-1:F];
  assign in_cy   = in_item_i.start_y[grt2d_pkg::COORD_W-1:F];
  assign in_idx  = cell_idx(in_cx, in_cy);
  assign wr_idx  = cell_idx(in_item_i.cell_x, in_item_i.cell_y);
  assign quad    = in_item_i.ray_angle[AB-1:AB-2];
  assign phase   = in_item_i.ray_angle[AB-3:0];
  assign ph_lo   = {1'b0, phase};
  assign ph_hi   = {1'b1, {(AB-2){1'b0}}} - {1'b0, phase};
  assign mag_lo  = sin_mag(ph_lo);
  assign mag_hi  = sin_mag(ph_hi);
  assign in_smag = quad[0] ? mag_hi : mag_lo;
  assign in_cmag = quad[0] ? mag_lo : mag_hi;

  // Divider operands: distance to the first boundary or one cell width
  always_comb begin
    unique case (sel_q)
      2'd0:    span = cneg_q ? {1'b0, fx_q} : DistW'((1 << F) - {1'b0, fx_q});
      2'd1:    span = sneg_q ? {1'b0, fy_q} : DistW'((1 << F) - {1'b0, fy_q});
      default: span = DistW'(1 << F);
    endcase
  end
  assign div_req.start = go_q;
  assign div_req.num   = NumW'(span) << (30 - F);
  assign div_req.den   = sel_q[0] ? smag_q : cmag_q;
  assign tq = (div_rsp.quot[NumW-1:TW] != '0) ? grt2d_pkg::T_SAT : div_rsp.quot[TW-1:0];

  // Next cell across the nearer boundary
  assign step_x = tmx_q < tmy_q;
  always_comb begin
    nx    = cx_q;
    ny    = cy_q;
    leave = 1'b0;
    if (step_x) begin
      if (cneg_q) begin
        leave = cx_q == '0;
        nx    = cx_q - 1'b1;
      end else begin
        leave = cx_q == 5'(GRID_SIZE - 1);
        nx    = cx_q + 1'b1;
      end
    end else begin
      if (sneg_q) begin
        leave = cy_q == '0;
        ny    = cy_q - 1'b1;
      end else begin
        leave = cy_q == 5'(GRID_SIZE - 1);
        ny    = cy_q + 1'b1;
      end
    end
  end
  assign cur_idx = cell_idx(cx_q, cy_q);
  assign nxt_idx = cell_idx(nx, ny);

  // Map ports: clear sweep or write item, start or step read
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_q;
    wdata = 1'b0;
    raddr = in_idx[AddrW-1:0];
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
    end else if (state_q == ST_IDLE && in_valid_i && in_item_i.cmd == grt2d_pkg::CMD_WRITE
                 && {1'b0, in_item_i.cell_x} < 6'(GRID_SIZE)
                 && {1'b0, in_item_i.cell_y} < 6'(GRID_SIZE)) begin
      we    = 1'b1;
      waddr = wr_idx[AddrW-1:0];
      wdata = in_item_i.wall_bit;
    end
    if (state_q == ST_STEP) begin
      raddr = nxt_idx[AddrW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    cmag_d      = cmag_q;
    smag_d      = smag_q;
    cneg_d      = cneg_q;
    sneg_d      = sneg_q;
    tmx_d       = tmx_q;
    tmy_d       = tmy_q;
    tdx_d       = tdx_q;
    tdy_d       = tdy_q;
    sel_d       = sel_q;
    go_d        = 1'b0;
    n_d         = n_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_item_i.cmd == grt2d_pkg::CMD_TRACE) begin
          cx_d   = in_cx;
          cy_d   = in_cy;
          fx_d   = in_item_i.start_x[F-1:0];
          fy_d   = in_item_i.start_y[F-1:0];
          cmag_d = in_cmag;
          smag_d = in_smag;
          cneg_d = (quad == 2'd1 || quad == 2'd2) && in_cmag != '0;
          sneg_d = quad[1] && in_smag != '0;
          n_d    = '0;
          if ({1'b0, in_cx} >= 6'(GRID_SIZE) || {1'b0, in_cy} >= 6'(GRID_SIZE)) begin
            out_d.cell_index = '0;
            out_d.kind       = grt2d_pkg::KIND_LEFT;
            out_d.last       = 1'b1;
            out_valid_d      = 1'b1;
            state_d          = ST_OUT;
          end else begin
            state_d = ST_START_CHK;
          end
        end
      end
      ST_START_CHK: begin
        if (rdata) begin
          out_d.cell_index = cur_idx;
          out_d.kind       = grt2d_pkg::KIND_START_WALL;
          out_d.last       = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_OUT;
        end else begin
          sel_d   = 2'd0;
          go_d    = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (sel_q)
            2'd0:    tmx_d = tq;
            2'd1:    tmy_d = tq;
            2'd2:    tdx_d = tq;
            default: tdy_d = tq;
          endcase
          if (sel_q == 2'd3) begin
            state_d = ST_STEP;
          end else begin
            sel_d = sel_q + 1'b1;
            go_d  = 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (leave) begin
          out_d.cell_index = cur_idx;
          out_d.kind       = grt2d_pkg::KIND_LEFT;
          out_d.last       = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_OUT;
        end else begin
          cx_d = nx;
          cy_d = ny;
          if (step_x) begin
            tmx_d = t_sat_add(tmx_q, tdx_q);
          end else begin
            tmy_d = t_sat_add(tmy_q, tdy_q);
          end
          state_d = ST_CELL_CHK;
        end
      end
      ST_CELL_CHK: begin
        out_d.cell_index = cur_idx;
        out_valid_d      = 1'b1;
        state_d          = ST_OUT;
        if (rdata) begin
          out_d.kind = grt2d_pkg::KIND_WALL;
          out_d.last = 1'b1;
        end else begin
          out_d.kind = grt2d_pkg::KIND_OPEN;
          out_d.last = n_q == '1;
          n_d        = n_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = out_q.last ? ST_IDLE : ST_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    cmag_q <= cmag_d;
    smag_q <= smag_d;
    cneg_q <= cneg_d;
    sneg_q <= sneg_d;
    tmx_q  <= tmx_d;
    tmy_q  <= tmy_d;
    tdx_q  <= tdx_d;
    tdy_q  <= tdy_d;
    sel_q  <= sel_d;
    n_q    <= n_d;
    out_q  <= out_d;
  end

  grt2d_ram #(
    .Width(1),
    .Depth(Depth)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  grt2d_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Stop kinds always close the trace
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != grt2d_pkg::KIND_OPEN |-> out_item_o.last)
    else $error("terminal kind without last");
  // Divider results arrive only during setup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider result outside setup");
  // No item is taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input open while result pending");

endmodule

`default_nettype wire

@@ sim/tb_grid_ray_traversal_2d_top.sv @@
// Testbench for grid_ray_traversal_2d_top: drives write and trace items with
// random idling and checks every cell result against a built-in predictor.
// Depends on grt2d_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_grid_ray_traversal_2d_top;

  localparam int GS = 32;
  localparam logic [23:0] TSAT = 24'hFFFFFF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  grt2d_pkg::in_item_t  in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  grt2d_pkg::out_item_t out_item_o;

  // Mirror of the wall map and queue of expected cell results
  bit                   wall_map [GS*GS];
  grt2d_pkg::out_item_t cells_due [$];
  int                   err_cnt = 0;
  bit                   calm = 1'b0;
  bit                   done_flag = 1'b0;

  grid_ray_traversal_2d_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_item_i(in_item_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Quarter-wave sine in Q1.14 from the Q30 polynomial
  function automatic logic [31:0] qsine(input int unsigned p);
    logic [63:0] x, x2, b, s, r;
    if (p == 0) return 0;
    if (p >= grt2d_pkg::QUARTER) return 16384;
    x  = 64'(p) << (32 - grt2d_pkg::ANGLE_BITS);
    x2 = (x * x) >> 30;
    b  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    b  = 64'd85569306 - ((x2 * b) >> 30);
    b  = 64'd693598668 - ((x2 * b) >> 30);
    b  = 64'd1686629713 - ((x2 * b) >> 30);
    s  = (x * b) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return 32'(r);
  endfunction

  function automatic logic [23:0] t_from(input logic [63:0] span, input logic [31:0] mag);
    logic [63:0] q;
    if (mag == 0) return TSAT;
    q = (span << (30 - grt2d_pkg::COORD_FRAC_BITS)) / mag;
    return (q > 64'(TSAT)) ? TSAT : q[23:0];
  endfunction

  function automatic logic [23:0] t_sum(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = a + b;
    return (s > 25'(TSAT)) ? TSAT : s[23:0];
  endfunction

  function automatic grt2d_pkg::out_item_t mk(input int idx, input grt2d_pkg::kind_e k,
                                              input bit l);
    grt2d_pkg::out_item_t o;
    o.cell_index = 10'(idx);
    o.kind = k;
    o.last = l;
    return o;
  endfunction

  // Append one expected result
  task automatic queue_cell(input int idx, input grt2d_pkg::kind_e k, input bit l);
    cells_due = {cells_due, mk(idx, k, l)};
  endtask

  function automatic grt2d_pkg::in_item_t rnd_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return grt2d_pkg::in_item_t'(r[$bits(grt2d_pkg::in_item_t)-1:0]);
  endfunction

  // Apply a write or walk a ray through the mirror map, queueing each cell entered
  task automatic predict_cells(input grt2d_pkg::in_item_t it);
    int cx, cy, nx, ny, stx, sty, n, idx;
    int unsigned quad, p, a, sx0, sy0;
    logic [31:0] cmag, smag;
    logic [23:0] tmx, tmy, tdx, tdy;
    bit cneg, sneg;
    if (it.cmd == grt2d_pkg::CMD_WRITE) begin
      if (it.cell_x < GS && it.cell_y < GS) wall_map[it.cell_x*GS + it.cell_y] = it.wall_bit;
      return;
    end
    sx0 = it.start_x; sy0 = it.start_y; a = it.ray_angle;
    cx = sx0 >> grt2d_pkg::COORD_FRAC_BITS; cy = sy0 >> grt2d_pkg::COORD_FRAC_BITS;
    if (cx >= GS || cy >= GS) begin
      queue_cell(0, grt2d_pkg::KIND_LEFT, 1'b1);
      return;
    end
    if (wall_map[cx*GS + cy]) begin
      queue_cell(cx*GS + cy, grt2d_pkg::KIND_START_WALL, 1'b1);
      return;
    end
    quad = a >> (grt2d_pkg::ANGLE_BITS - 2);
    p = a & (grt2d_pkg::QUARTER - 1);
    smag = quad[0] ? qsine(grt2d_pkg::QUARTER - p) : qsine(p);
    cmag = quad[0] ? qsine(p) : qsine(grt2d_pkg::QUARTER - p);
    sneg = (quad >= 2) && smag != 0;
    cneg = (quad == 1 || quad == 2) && cmag != 0;
    stx = cneg ? -1 : 1;
    sty = sneg ? -1 : 1;
    tmx = cneg ? t_from(sx0 - (cx << grt2d_pkg::COORD_FRAC_BITS), cmag)
               : t_from(((cx + 1) << grt2d_pkg::COORD_FRAC_BITS) - sx0, cmag);
    tmy = sneg ? t_from(sy0 - (cy << grt2d_pkg::COORD_FRAC_BITS), smag)
               : t_from(((cy + 1) << grt2d_pkg::COORD_FRAC_BITS) - sy0, smag);
    tdx = t_from(1 << grt2d_pkg::COORD_FRAC_BITS, cmag);
    tdy = t_from(1 << grt2d_pkg::COORD_FRAC_BITS, smag);
    n = 0;
    forever begin
      nx = cx; ny = cy;
      if (tmx < tmy) begin
        nx += stx; tmx = t_sum(tmx, tdx);
      end else begin
        ny += sty; tmy = t_sum(tmy, tdy);
      end
      if (nx < 0 || ny < 0 || nx >= GS || ny >= GS) begin
        queue_cell(cx*GS + cy, grt2d_pkg::KIND_LEFT, 1'b1);
        return;
      end
      cx = nx; cy = ny; idx = cx*GS + cy;
      if (wall_map[idx]) begin
        queue_cell(idx, grt2d_pkg::KIND_WALL, 1'b1);
        return;
      end
      if (n == grt2d_pkg::MAX_RESULTS - 1) begin
        queue_cell(idx, grt2d_pkg::KIND_OPEN, 1'b1);
        return;
      end
      queue_cell(idx, grt2d_pkg::KIND_OPEN, 1'b0);
      n++;
    end
  endtask

  // Send one item, idling at random first; predict on acceptance
  task automatic send_item(input grt2d_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cells(it);
    @(negedge clk_i);
  endtask

  task automatic put_wall(input int x, input int y, input bit w);
    grt2d_pkg::in_item_t it;
    it = rnd_item();
    it.cmd = grt2d_pkg::CMD_WRITE; it.cell_x = 5'(x); it.cell_y = 5'(y); it.wall_bit = w;
    send_item(it);
  endtask

  task automatic shoot(input int sx, input int sy, input int ang);
    grt2d_pkg::in_item_t it;
    it = rnd_item();
    it.cmd = grt2d_pkg::CMD_TRACE;
    it.start_x = grt2d_pkg::COORD_W'(sx);
    it.start_y = grt2d_pkg::COORD_W'(sy);
    it.ray_angle = grt2d_pkg::ANGLE_BITS'(ang);
    send_item(it);
  endtask

  // Drop valid and wait for every expected result
  task automatic drain_cells();
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk_i);
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    grt2d_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cells_due.size() == 0) begin
        report("unexpected result", out_item_o, 0);
      end else begin
        want = cells_due.pop_front();
        if (out_item_o.cell_index !== want.cell_index)
          report("cell_index", out_item_o.cell_index, want.cell_index);
        if (out_item_o.kind !== want.kind) report("kind", out_item_o.kind, want.kind);
        if (out_item_o.last !== want.last) report("last", out_item_o.last, want.last);
      end
    end
  end

  // Receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 11);
  end

  // Axis rays, quadrant boundaries, corners, out-of-grid starts
  task automatic test_directed();
    shoot(0, 0, 0);
    shoot(8191, 8191, 512);
    shoot(16*256 + 128, 16*256 + 128, 256);
    shoot(16*256 + 128, 16*256 + 128, 768);
    shoot(16*256, 16*256, 1023);
    shoot(31*256 + 255, 0, 384);
    shoot(0, 31*256 + 255, 640);
    shoot(32*256, 5*256, 100);
    shoot(5*256, 32*256, 100);
    shoot(1*256, 1*256, 128);
    put_wall(10, 10, 1'b1);
    shoot(10*256 + 7, 10*256 + 200, 50);
    shoot(4*256 + 128, 10*256 + 128, 0);
    shoot(10*256 + 128, 2*256 + 128, 256);
    put_wall(31, 31, 1'b1);
    put_wall(10, 10, 1'b0);
    shoot(10*256, 10*256, 900);
    drain_cells();
  endtask

  // Walls placed at random among rays of random origin and direction
  task automatic test_random_traces();
    for (int i = 0; i < 310; i++) begin
      if ($urandom_range(99) < 30) begin
        put_wall($urandom_range(31), $urandom_range(31), $urandom_range(99) < 60);
      end else if ($urandom_range(99) < 5) begin
        shoot($urandom_range(8191), $urandom_range(8191), $urandom_range(1023));
      end else begin
        shoot($urandom_range(32*256 - 1), $urandom_range(32*256 - 1), $urandom_range(1023));
      end
      if (i == 120) drain_cells();
    end
  endtask

  // A stretch with no idling on either side
  task automatic test_full_rate();
    calm = 1'b1;
    for (int i = 0; i < 30; i++)
      shoot($urandom_range(32*256 - 1), $urandom_range(32*256 - 1), $urandom_range(1023));
    drain_cells();
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_traces();
    test_full_rate();
    drain_cells();
    repeat (300) @(negedge clk_i);
    if (err_cnt == 0 && cells_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    done_flag = 1'b1;
    $finish;
  end

  // Run time guard
  initial begin
    #(8 * 600000);
    if (!done_flag) $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/grt2d_pkg.sv
hw/rtl/grt2d_ram.sv
hw/rtl/grt2d_div.sv
hw/rtl/grid_ray_traversal_2d_top.sv
sim/tb_grid_ray_traversal_2d_top.sv
